[hw/rtl/pvp_pkg.sv]
// Shared codes for the viewport planner: blit paths, present modes and scale classes.
package pvp_pkg;

   localparam logic [1:0] PATH_NONE         = 2'd0;
   localparam logic [1:0] PATH_NATIVE_FULL  = 2'd1;
   localparam logic [1:0] PATH_NATIVE_DIRTY = 2'd2;
   localparam logic [1:0] PATH_STRETCH      = 2'd3;

   localparam logic [2:0] MODE_NATIVE       = 3'd0;
   localparam logic [2:0] MODE_STRETCH      = 3'd1;
   localparam logic [2:0] MODE_FIXED_HEIGHT = 3'd2;
   localparam logic [2:0] MODE_OVERSCAN     = 3'd3;

   typedef enum logic [1:0] {
      CLS_NATIVE  = 2'd0,
      CLS_STRETCH = 2'd1,
      CLS_LETTER  = 2'd2,
      CLS_OVER    = 2'd3
   } cls_type;

endpackage

[hw/rtl/pvp_front.sv]
// Front stage: classifies a request, forms the two aspect products and clips the dirty rectangle.
module pvp_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [2:0]                     mode,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic signed [COORD_BITS-1:0]   client_width,
   input  logic signed [COORD_BITS-1:0]   client_height,
   input  logic signed [COORD_BITS-1:0]   source_width,
   input  logic signed [COORD_BITS-1:0]   source_height,
   input  logic                           dirty_requested,
   input  logic                           needs_repair,
   input  logic                           fully_dirty,
   input  logic                           dirty_valid,
   input  logic signed [COORD_BITS-1:0]   dirty_left,
   input  logic signed [COORD_BITS-1:0]   dirty_top,
   input  logic signed [COORD_BITS-1:0]   dirty_span_x,
   input  logic signed [COORD_BITS-1:0]   dirty_span_y,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_empty,
   output pvp_pkg::cls_type               out_cls,
   output logic [COORD_BITS-2:0]          out_cw,
   output logic [COORD_BITS-2:0]          out_ch,
   output logic [COORD_BITS-2:0]          out_sw,
   output logic [COORD_BITS-2:0]          out_sh,
   output logic [2*COORD_BITS-3:0]        out_ax,
   output logic [2*COORD_BITS-3:0]        out_ay,
   output logic                           out_full,
   output logic                           out_dok,
   output logic [COORD_BITS-2:0]          out_sl,
   output logic [COORD_BITS-2:0]          out_st,
   output logic [COORD_BITS-2:0]          out_ssx,
   output logic [COORD_BITS-2:0]          out_ssy
);
   import pvp_pkg::*;

   localparam int B = COORD_BITS;
   localparam int P = COORD_BITS - 1;

   function automatic logic signed [B:0] clip(input logic signed [B:0] v,
                                              input logic signed [B:0] hi);
      logic signed [B:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > hi) begin
         res = hi;
      end else begin
         res = v;
      end
      return res;
   endfunction

   logic              vld_ff, vld_in;
   logic              take;
   logic              empty;
   cls_type           cls;
   logic signed [B:0] sw_ext, sh_ext, l, t, r, b;

   assign in_ready = !vld_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign vld_in   = take ? 1'b1 : (out_ready ? 1'b0 : vld_ff);
   assign out_valid = vld_ff;

   assign empty = (client_width <= 0) || (client_height <= 0) ||
                  (source_width <= 0) || (source_height <= 0);

   always_comb begin
      case (mode)
         MODE_NATIVE:       cls = CLS_NATIVE;
         MODE_STRETCH:      cls = CLS_STRETCH;
         MODE_FIXED_HEIGHT: cls = CLS_STRETCH;
         MODE_OVERSCAN:     cls = CLS_OVER;
         default:           cls = CLS_LETTER;
      endcase
   end

   assign sw_ext = $signed({1'b0, source_width});
   assign sh_ext = $signed({1'b0, source_height});
   assign l = clip($signed({dirty_left[B-1], dirty_left}), sw_ext);
   assign t = clip($signed({dirty_top[B-1], dirty_top}), sh_ext);
   assign r = clip($signed({dirty_left[B-1], dirty_left}) +
                   $signed({dirty_span_x[B-1], dirty_span_x}), sw_ext);
   assign b = clip($signed({dirty_top[B-1], dirty_top}) +
                   $signed({dirty_span_y[B-1], dirty_span_y}), sh_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_empty <= empty;
         out_cls   <= cls;
         out_cw    <= client_width[P-1:0];
         out_ch    <= client_height[P-1:0];
         out_sw    <= source_width[P-1:0];
         out_sh    <= source_height[P-1:0];
         out_ax    <= client_width[P-1:0] * source_height[P-1:0];
         out_ay    <= client_height[P-1:0] * source_width[P-1:0];
         out_full  <= !dirty_requested || needs_repair || fully_dirty;
         out_dok   <= dirty_valid && (r > l) && (b > t);
         out_sl    <= l[P-1:0];
         out_st    <= t[P-1:0];
         out_ssx   <= P'(r - l);
         out_ssy   <= P'(b - t);
      end
   end
endmodule

[hw/rtl/pvp_queue.sv]
// Two-entry queue that decouples the front stage from the scaling back end.
module pvp_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [0:1];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rp_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign wp_in      = push ? !wp_ff : wp_ff;
   assign rp_in      = pop ? !rp_ff : rp_ff;
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end
endmodule

[hw/rtl/pvp_back.sv]
// Back end: picks the scale axis, divides one quotient bit per stage and builds the plan.
module pvp_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_empty,
   input  pvp_pkg::cls_type             in_cls,
   input  logic [COORD_BITS-2:0]        in_cw,
   input  logic [COORD_BITS-2:0]        in_ch,
   input  logic [COORD_BITS-2:0]        in_sw,
   input  logic [COORD_BITS-2:0]        in_sh,
   input  logic [2*COORD_BITS-3:0]      in_ax,
   input  logic [2*COORD_BITS-3:0]      in_ay,
   input  logic                         in_full,
   input  logic                         in_dok,
   input  logic [COORD_BITS-2:0]        in_sl,
   input  logic [COORD_BITS-2:0]        in_st,
   input  logic [COORD_BITS-2:0]        in_ssx,
   input  logic [COORD_BITS-2:0]        in_ssy,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [1:0]                   blit_path,
   output logic                         clear_client,
   output logic signed [COORD_BITS-1:0] dest_left,
   output logic signed [COORD_BITS-1:0] dest_top,
   output logic [COORD_BITS-1:0]        dest_span_x,
   output logic [COORD_BITS-1:0]        dest_span_y,
   output logic [COORD_BITS-2:0]        src_left,
   output logic [COORD_BITS-2:0]        src_top,
   output logic [COORD_BITS-2:0]        src_span_x,
   output logic [COORD_BITS-2:0]        src_span_y
);
   import pvp_pkg::*;

   localparam int B  = COORD_BITS;
   localparam int P  = COORD_BITS - 1;
   localparam int ND = 2 * P;
   localparam int WW = 2 * P + 2;
   localparam int WD = WW + 1;
   localparam int PW = 3 + 1 + 1 + 1 + 8 * P;

   logic          adv;
   logic          vld_ff [0:ND];
   logic [ND-1:0] num_ff [0:ND];
   logic [ND-1:0] q_ff   [0:ND];
   logic [P-1:0]  rem_ff [0:ND];
   logic [P-1:0]  den_ff [0:ND];
   logic [PW-1:0] pl_ff  [0:ND];
   logic [ND-1:0] num_nx [1:ND];
   logic [ND-1:0] q_nx   [1:ND];
   logic [P-1:0]  rem_nx [1:ND];
   logic          usex0;
   logic [PW-1:0] pl0;
   logic          out_vld_ff, out_vld_in;

   assign adv      = !out_vld_ff || out_ready;
   assign in_ready = adv;
   assign out_valid = out_vld_ff;

   assign usex0 = (in_cls == CLS_OVER) ? (in_ax >= in_ay) : (in_ax <= in_ay);
   assign pl0   = {in_empty, in_cls, usex0, in_full, in_dok, in_cw, in_ch, in_sw, in_sh,
                   in_sl, in_st, in_ssx, in_ssy};

   // One restoring division step per stage.
   for (genvar i = 1; i <= ND; i++) begin : g_step
      logic [P:0] trial;
      logic       ge;
      assign trial     = {rem_ff[i-1], num_ff[i-1][ND-1]};
      assign ge        = trial >= {1'b0, den_ff[i-1]};
      assign rem_nx[i] = ge ? P'(trial - {1'b0, den_ff[i-1]}) : trial[P-1:0];
      assign q_nx[i]   = {q_ff[i-1][ND-2:0], ge};
      assign num_nx[i] = {num_ff[i-1][ND-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= ND; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i <= ND; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff[0] <= usex0 ? in_ax : in_ay;
         den_ff[0] <= usex0 ? in_sw : in_sh;
         rem_ff[0] <= '0;
         q_ff[0]   <= '0;
         pl_ff[0]  <= pl0;
         for (int i = 1; i <= ND; i++) begin
            num_ff[i] <= num_nx[i];
            den_ff[i] <= den_ff[i-1];
            rem_ff[i] <= rem_nx[i];
            q_ff[i]   <= q_nx[i];
            pl_ff[i]  <= pl_ff[i-1];
         end
      end
   end

   // Plan assembly from the last division stage.
   logic          f_empty, f_usex, f_full, f_dok;
   logic [1:0]    f_cls_bits;
   cls_type       f_cls;
   logic [P-1:0]  f_cw, f_ch, f_sw, f_sh, f_sl, f_st, f_ssx, f_ssy;
   logic [ND:0]   qr;
   logic [WW-1:0] scl, wid, hei;
   logic          fit, scaled;
   logic signed [WD-1:0] dxd, dyd, dxh, dyh, dxs, dys;
   localparam logic signed [WD-1:0] SMAX = {{(WD-P){1'b0}}, {P{1'b1}}};
   localparam logic signed [WD-1:0] SMIN = {{(WD-P){1'b1}}, {P{1'b0}}};
   localparam logic [WW-1:0] UMAX = {{(WW-B){1'b0}}, {B{1'b1}}};

   assign {f_empty, f_cls_bits, f_usex, f_full, f_dok, f_cw, f_ch, f_sw, f_sh,
           f_sl, f_st, f_ssx, f_ssy} = pl_ff[ND];
   assign f_cls = cls_type'(f_cls_bits);

   assign qr  = {1'b0, q_ff[ND]} +
                {{ND{1'b0}}, ({rem_ff[ND], 1'b0} >= {1'b0, den_ff[ND]})};
   assign scl = (qr == '0) ? {{(WW-1){1'b0}}, 1'b1} : {1'b0, qr};
   assign fit = (f_cls == CLS_LETTER) || (f_cls == CLS_OVER);

   always_comb begin
      case (f_cls)
         CLS_NATIVE: begin
            wid = {{(WW-P){1'b0}}, f_sw};
            hei = {{(WW-P){1'b0}}, f_sh};
         end
         CLS_STRETCH: begin
            wid = {{(WW-P){1'b0}}, f_cw};
            hei = {{(WW-P){1'b0}}, f_ch};
         end
         default: begin
            wid = f_usex ? {{(WW-P){1'b0}}, f_cw} : scl;
            hei = f_usex ? scl : {{(WW-P){1'b0}}, f_ch};
         end
      endcase
   end

   assign dxd = $signed({{(WD-P){1'b0}}, f_cw}) - $signed({1'b0, wid});
   assign dyd = $signed({{(WD-P){1'b0}}, f_ch}) - $signed({1'b0, hei});
   assign dxh = dxd[WD-1] ? ((dxd + 1) >>> 1) : (dxd >>> 1);
   assign dyh = dyd[WD-1] ? ((dyd + 1) >>> 1) : (dyd >>> 1);
   assign dxs = (dxh > SMAX) ? SMAX : ((dxh < SMIN) ? SMIN : dxh);
   assign dys = (dyh > SMAX) ? SMAX : ((dyh < SMIN) ? SMIN : dyh);
   assign scaled = (wid != {{(WW-P){1'b0}}, f_sw}) || (hei != {{(WW-P){1'b0}}, f_sh});

   assign out_vld_in = adv ? vld_ff[ND] : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         blit_path    <= PATH_NONE;
         clear_client <= 1'b0;
         dest_left    <= '0;
         dest_top     <= '0;
         dest_span_x  <= '0;
         dest_span_y  <= '0;
         src_left     <= '0;
         src_top      <= '0;
         src_span_x   <= '0;
         src_span_y   <= '0;
         if (!f_empty) begin
            dest_left   <= fit ? dxs[B-1:0] : '0;
            dest_top    <= fit ? dys[B-1:0] : '0;
            dest_span_x <= (wid > UMAX) ? {B{1'b1}} : wid[B-1:0];
            dest_span_y <= (hei > UMAX) ? {B{1'b1}} : hei[B-1:0];
            if (f_full || scaled) begin
               blit_path    <= scaled ? PATH_STRETCH : PATH_NATIVE_FULL;
               clear_client <= 1'b1;
               src_span_x   <= f_sw;
               src_span_y   <= f_sh;
            end else if (f_dok) begin
               blit_path  <= PATH_NATIVE_DIRTY;
               src_left   <= f_sl;
               src_top    <= f_st;
               src_span_x <= f_ssx;
               src_span_y <= f_ssy;
            end
         end
      end
   end
endmodule

[hw/rtl/present_viewport_planner.sv]
// Top level of the viewport planner: front stage, decoupling queue and scaling back end.
// Each request beat passes through the front register, the queue, the one-bit-per-stage divider
// and the output register before its plan beat can be taken.
// Throughput: one request per cycle while the plan consumer keeps rsp_ready high.
// Reset (synchronous, active high) empties the front register, queue and back pipeline
// and sets present_mode to native; no clearing pass is needed.
module present_viewport_planner #(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [2:0]                   csr_present_mode,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_client_width,
   input  logic signed [COORD_BITS-1:0] req_client_height,
   input  logic signed [COORD_BITS-1:0] req_source_width,
   input  logic signed [COORD_BITS-1:0] req_source_height,
   input  logic                         req_dirty_requested,
   input  logic                         req_needs_repair,
   input  logic                         req_fully_dirty,
   input  logic                         req_dirty_valid,
   input  logic signed [COORD_BITS-1:0] req_dirty_left,
   input  logic signed [COORD_BITS-1:0] req_dirty_top,
   input  logic signed [COORD_BITS-1:0] req_dirty_span_x,
   input  logic signed [COORD_BITS-1:0] req_dirty_span_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_blit_path,
   output logic                         rsp_clear_client,
   output logic signed [COORD_BITS-1:0] rsp_dest_left,
   output logic signed [COORD_BITS-1:0] rsp_dest_top,
   output logic [COORD_BITS-1:0]        rsp_dest_span_x,
   output logic [COORD_BITS-1:0]        rsp_dest_span_y,
   output logic [COORD_BITS-2:0]        rsp_src_left,
   output logic [COORD_BITS-2:0]        rsp_src_top,
   output logic [COORD_BITS-2:0]        rsp_src_span_x,
   output logic [COORD_BITS-2:0]        rsp_src_span_y
);
   import pvp_pkg::*;

   localparam int P  = COORD_BITS - 1;
   localparam int QW = 12 * P + 5;

   // The mode register is sampled when a request beat enters the front stage.
   logic [2:0] mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NATIVE;
      end else if (csr_valid) begin
         mode_ff <= csr_present_mode;
      end
   end

   logic            f_valid, f_ready, f_empty, f_full, f_dok;
   cls_type         f_cls;
   logic [P-1:0]    f_cw, f_ch, f_sw, f_sh, f_sl, f_st, f_ssx, f_ssy;
   logic [2*P-1:0]  f_ax, f_ay;

   pvp_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock           (clock),
      .reset           (reset),
      .mode            (mode_ff),
      .in_valid        (req_valid),
      .in_ready        (req_ready),
      .client_width    (req_client_width),
      .client_height   (req_client_height),
      .source_width    (req_source_width),
      .source_height   (req_source_height),
      .dirty_requested (req_dirty_requested),
      .needs_repair    (req_needs_repair),
      .fully_dirty     (req_fully_dirty),
      .dirty_valid     (req_dirty_valid),
      .dirty_left      (req_dirty_left),
      .dirty_top       (req_dirty_top),
      .dirty_span_x    (req_dirty_span_x),
      .dirty_span_y    (req_dirty_span_y),
      .out_valid       (f_valid),
      .out_ready       (f_ready),
      .out_empty       (f_empty),
      .out_cls         (f_cls),
      .out_cw          (f_cw),
      .out_ch          (f_ch),
      .out_sw          (f_sw),
      .out_sh          (f_sh),
      .out_ax          (f_ax),
      .out_ay          (f_ay),
      .out_full        (f_full),
      .out_dok         (f_dok),
      .out_sl          (f_sl),
      .out_st          (f_st),
      .out_ssx         (f_ssx),
      .out_ssy         (f_ssy)
   );

   // The queue lets the front keep taking beats while the back end is stalled.
   logic [QW-1:0] q_in, q_out;
   logic          q_valid, q_ready;

   assign q_in = {f_empty, f_cls, f_cw, f_ch, f_sw, f_sh, f_ax, f_ay, f_full, f_dok,
                  f_sl, f_st, f_ssx, f_ssy};

   pvp_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (q_in),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_out)
   );

   logic            b_empty, b_full, b_dok;
   logic [1:0]      b_cls_bits;
   logic [P-1:0]    b_cw, b_ch, b_sw, b_sh, b_sl, b_st, b_ssx, b_ssy;
   logic [2*P-1:0]  b_ax, b_ay;

   assign {b_empty, b_cls_bits, b_cw, b_ch, b_sw, b_sh, b_ax, b_ay, b_full, b_dok,
           b_sl, b_st, b_ssx, b_ssy} = q_out;

   pvp_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_empty     (b_empty),
      .in_cls       (cls_type'(b_cls_bits)),
      .in_cw        (b_cw),
      .in_ch        (b_ch),
      .in_sw        (b_sw),
      .in_sh        (b_sh),
      .in_ax        (b_ax),
      .in_ay        (b_ay),
      .in_full      (b_full),
      .in_dok       (b_dok),
      .in_sl        (b_sl),
      .in_st        (b_st),
      .in_ssx       (b_ssx),
      .in_ssy       (b_ssy),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .blit_path    (rsp_blit_path),
      .clear_client (rsp_clear_client),
      .dest_left    (rsp_dest_left),
      .dest_top     (rsp_dest_top),
      .dest_span_x  (rsp_dest_span_x),
      .dest_span_y  (rsp_dest_span_y),
      .src_left     (rsp_src_left),
      .src_top      (rsp_src_top),
      .src_span_x   (rsp_src_span_x),
      .src_span_y   (rsp_src_span_y)
   );
endmodule

[hw/rtl/pvp_checker.sv]
// Port-level checks on the plan channel of the viewport planner, with its bind.
module pvp_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [1:0]            rsp_blit_path,
   input logic                  rsp_clear_client,
   input logic [COORD_BITS-1:0] rsp_dest_span_x,
   input logic [COORD_BITS-2:0] rsp_src_span_x,
   input logic [COORD_BITS-2:0] rsp_src_span_y
);
   import pvp_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blit_path) &&
      $stable(rsp_src_span_x))
      else $error("plan beat changed while stalled");

   a_clear_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clear_client |->
      (rsp_blit_path == PATH_NATIVE_FULL) || (rsp_blit_path == PATH_STRETCH))
      else $error("clear without a full copy");

   a_dirty_area: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_blit_path == PATH_NATIVE_DIRTY) |->
      (rsp_src_span_x != '0) && (rsp_src_span_y != '0) && !rsp_clear_client)
      else $error("dirty blit with empty area");

   a_none_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_blit_path == PATH_NONE) |->
      (rsp_src_span_x == '0) && (rsp_src_span_y == '0))
      else $error("no blit but a source area");

   a_full_dest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_blit_path != PATH_NONE) |-> (rsp_dest_span_x != '0))
      else $error("blit into an empty destination");
endmodule

bind present_viewport_planner pvp_checker #(.COORD_BITS(COORD_BITS)) u_pvp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_blit_path    (rsp_blit_path),
   .rsp_clear_client (rsp_clear_client),
   .rsp_dest_span_x  (rsp_dest_span_x),
   .rsp_src_span_x   (rsp_src_span_x),
   .rsp_src_span_y   (rsp_src_span_y)
);

[bench/tb_present_viewport_planner.sv]
// Self-checking testbench for the viewport planner: directed plans, random plans, stalls.
module tb_present_viewport_planner;
   import pvp_pkg::*;

   // Mode code 4 (aspect fit letterbox) has no name in the package.
   localparam logic [2:0] MODE_LETTERBOX = 3'd4;
   localparam int LATENCY   = 34;
   localparam int MAX_CYCLE = 2000000;

   typedef struct packed {
      logic signed [15:0] cw, ch, sw, sh;
      logic dreq, repair, fully, dvalid;
      logic signed [15:0] dl, dt, dw, dh;
   } frame_req_type;

   typedef struct packed {
      logic [1:0] path;
      logic clear;
      logic signed [15:0] dx, dy;
      logic [15:0] wid, hei;
      logic [14:0] sl, st, ssx, ssy;
   } plan_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0, csr_ready;
   logic [2:0] csr_present_mode = '0;
   logic req_valid = 1'b0, req_ready;
   frame_req_type req_beat = '0;
   logic rsp_valid, rsp_ready = 1'b0;
   plan_type got;

   logic [2:0] mode_shadow;
   plan_type expected_plans[$];
   int errors = 0;
   int cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 1'b0;

   present_viewport_planner i_dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_present_mode(csr_present_mode),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_client_width(req_beat.cw), .req_client_height(req_beat.ch),
      .req_source_width(req_beat.sw), .req_source_height(req_beat.sh),
      .req_dirty_requested(req_beat.dreq), .req_needs_repair(req_beat.repair),
      .req_fully_dirty(req_beat.fully), .req_dirty_valid(req_beat.dvalid),
      .req_dirty_left(req_beat.dl), .req_dirty_top(req_beat.dt),
      .req_dirty_span_x(req_beat.dw), .req_dirty_span_y(req_beat.dh),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_blit_path(got.path), .rsp_clear_client(got.clear),
      .rsp_dest_left(got.dx), .rsp_dest_top(got.dy),
      .rsp_dest_span_x(got.wid), .rsp_dest_span_y(got.hei),
      .rsp_src_left(got.sl), .rsp_src_top(got.st),
      .rsp_src_span_x(got.ssx), .rsp_src_span_y(got.ssy)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // The run ends here if anything hangs.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("tb_present_viewport_planner NOT OK");
         $finish;
      end
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Halves round up; the numerator is never negative here.
   function automatic longint div_round(longint num, longint den);
      return (2 * num + den) / (2 * den);
   endfunction

   // Works out the plan for one frame request under the current mode.
   function automatic plan_type plan_frame(frame_req_type r, logic [2:0] mode);
      plan_type p;
      longint cw, ch, sw, sh, wid, hei, dx, dy, ax, ay, l, t, rr, b;
      bit use_x, scaled;
      p = '0;
      cw = r.cw; ch = r.ch; sw = r.sw; sh = r.sh;
      dx = 0; dy = 0;
      // Any non-positive size yields an all-zero plan.
      if (cw <= 0 || ch <= 0 || sw <= 0 || sh <= 0) return p;
      if (mode == MODE_NATIVE) begin
         wid = sw; hei = sh;
      end else if (mode == MODE_STRETCH || mode == MODE_FIXED_HEIGHT) begin
         wid = cw; hei = ch;
      end else begin
         // Overscan takes the larger axis scale; letterbox and spare codes the smaller.
         ax = cw * sh;
         ay = ch * sw;
         use_x = (mode == MODE_OVERSCAN) ? (ax >= ay) : (ax <= ay);
         if (use_x) begin
            wid = cw; hei = div_round(sh * cw, sw);
         end else begin
            hei = ch; wid = div_round(sw * ch, sh);
         end
         if (wid < 1) wid = 1;
         if (hei < 1) hei = 1;
         dx = clip((cw - wid) / 2, -32768, 32767);
         dy = clip((ch - hei) / 2, -32768, 32767);
      end
      scaled = (wid != sw) || (hei != sh);
      if (!r.dreq || r.repair || r.fully || scaled) begin
         p.path = scaled ? PATH_STRETCH : PATH_NATIVE_FULL;
         p.clear = 1'b1;
         p.ssx = sw[14:0]; p.ssy = sh[14:0];
      end else if (r.dvalid) begin
         // The dirty rectangle is clipped to the source; nothing left means no blit.
         l = clip(r.dl, 0, sw);
         t = clip(r.dt, 0, sh);
         rr = clip(longint'(r.dl) + r.dw, 0, sw);
         b = clip(longint'(r.dt) + r.dh, 0, sh);
         if (rr > l && b > t) begin
            p.path = PATH_NATIVE_DIRTY;
            p.sl = l[14:0]; p.st = t[14:0];
            p.ssx = 15'(rr - l); p.ssy = 15'(b - t);
         end
      end
      p.dx = dx[15:0]; p.dy = dy[15:0];
      p.wid = 16'(clip(wid, 0, 65535)); p.hei = 16'(clip(hei, 0, 65535));
      return p;
   endfunction

   task automatic report_mismatch(string what, longint seen, longint want);
      $display("mismatch %s: got %0d expected %0d", what, seen, want);
      errors++;
   endtask

   // Receiver: random stalls, plus a long hold-off when asked; checks every plan beat.
   always @(posedge clock) begin
      plan_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_plans.size() == 0) begin
            report_mismatch("unexpected plan beat", 1, 0);
         end else begin
            e = expected_plans.pop_front();
            if (got.path != e.path) report_mismatch("blit_path", got.path, e.path);
            if (got.clear != e.clear) report_mismatch("clear_client", got.clear, e.clear);
            if (got.dx != e.dx) report_mismatch("dest_left", got.dx, e.dx);
            if (got.dy != e.dy) report_mismatch("dest_top", got.dy, e.dy);
            if (got.wid != e.wid) report_mismatch("dest_span_x", got.wid, e.wid);
            if (got.hei != e.hei) report_mismatch("dest_span_y", got.hei, e.hei);
            if (got.sl != e.sl) report_mismatch("src_left", got.sl, e.sl);
            if (got.st != e.st) report_mismatch("src_top", got.st, e.st);
            if (got.ssx != e.ssx) report_mismatch("src_span_x", got.ssx, e.ssx);
            if (got.ssy != e.ssy) report_mismatch("src_span_y", got.ssy, e.ssy);
         end
      end
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // Sends one request beat; the sender may idle first according to send_idle_pct.
   // Valid stays high after the beat until the sender idles or the caller drops it.
   task automatic send_frame(frame_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_plans.push_back(plan_frame(r, mode_shadow));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_plans.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // Mode writes happen only with the pipeline empty.
   task automatic write_mode(logic [2:0] m);
      drain();
      csr_valid <= 1'b1;
      csr_present_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mode_shadow = m;
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] pick_size();
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: return 16'($urandom_range(32767, 30000));
         2: return 16'($urandom_range(3));
         default: return 16'($urandom_range(4096, 1));
      endcase
   endfunction

   function automatic frame_req_type random_frame();
      frame_req_type r;
      r = '0;
      r.cw = pick_size(); r.ch = pick_size();
      r.sw = pick_size(); r.sh = pick_size();
      // Often make client equal to source so the dirty paths are reached in native mode.
      if ($urandom_range(2) == 0) begin
         r.cw = r.sw; r.ch = r.sh;
      end
      r.dreq = $urandom_range(3) != 0;
      r.repair = $urandom_range(5) == 0;
      r.fully = $urandom_range(5) == 0;
      r.dvalid = $urandom_range(4) != 0;
      if ($urandom_range(3) == 0) begin
         r.dl = 16'($urandom); r.dt = 16'($urandom);
         r.dw = 16'($urandom); r.dh = 16'($urandom);
      end else begin
         r.dl = 16'($urandom_range(600)) - 16'sd50;
         r.dt = 16'($urandom_range(600)) - 16'sd50;
         r.dw = 16'($urandom_range(700)) - 16'sd50;
         r.dh = 16'($urandom_range(700)) - 16'sd50;
      end
      return r;
   endfunction

   function automatic frame_req_type make_frame(int cw, int ch, int sw, int sh, bit dreq,
                                                bit repair, bit fully, bit dvalid,
                                                int dl, int dt, int dw, int dh);
      frame_req_type r;
      r.cw = 16'(cw); r.ch = 16'(ch); r.sw = 16'(sw); r.sh = 16'(sh);
      r.dreq = dreq; r.repair = repair; r.fully = fully; r.dvalid = dvalid;
      r.dl = 16'(dl); r.dt = 16'(dt); r.dw = 16'(dw); r.dh = 16'(dh);
      return r;
   endfunction

   // Extremes, every mode, empty plans, and each dirty-rectangle case.
   task automatic test_directed;
      logic [2:0] m;
      for (int k = 0; k <= 7; k++) begin
         m = 3'(k);
         write_mode(m);
         send_frame(make_frame(640, 480, 320, 240, 0, 0, 0, 0, 0, 0, 0, 0));
         send_frame(make_frame(32767, 1, 1, 32767, 1, 0, 0, 1, 0, 0, 1, 1));
      end
      write_mode(MODE_NATIVE);
      send_frame(make_frame(0, 480, 320, 240, 1, 0, 0, 1, 0, 0, 5, 5));
      send_frame(make_frame(640, -32768, 320, 240, 1, 0, 0, 1, 0, 0, 5, 5));
      send_frame(make_frame(640, 480, -1, 240, 1, 0, 0, 1, 0, 0, 5, 5));
      send_frame(make_frame(320, 240, 320, 240, 1, 0, 0, 1, 10, 20, 30, 40));
      send_frame(make_frame(320, 240, 320, 240, 1, 0, 0, 0, 10, 20, 30, 40));
      send_frame(make_frame(320, 240, 320, 240, 1, 1, 0, 1, 10, 20, 30, 40));
      send_frame(make_frame(320, 240, 320, 240, 1, 0, 1, 1, 10, 20, 30, 40));
      send_frame(make_frame(320, 240, 320, 240, 1, 0, 0, 1, 400, 0, 30, 40));
      send_frame(make_frame(32767, 32767, 32767, 32767, 1, 0, 0, 1,
                            -32768, -32768, 32767, 32767));
      send_frame(make_frame(32767, 32767, 32767, 32767, 1, 0, 0, 1,
                            32767, 32767, 32767, -32768));
      write_mode(MODE_LETTERBOX);
      send_frame(make_frame(32767, 32767, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      send_frame(make_frame(1, 1, 32767, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
      write_mode(MODE_OVERSCAN);
      send_frame(make_frame(32767, 1, 1, 32767, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random(int count, int s_idle, int r_idle);
      logic [2:0] m;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (int k = 0; k < count; k++) begin
         if (k % 100 == 0) begin
            m = 3'($urandom_range(7));
            write_mode(m);
         end
         send_frame(random_frame());
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_backpressure;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_mode(MODE_LETTERBOX);
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int k = 0; k < 100; k++) send_frame(random_frame());
            req_valid <= 1'b0;
         end
      join
      // The sender pauses until every plan is back before going on.
      drain();
   endtask

   initial begin
      mode_shadow = MODE_NATIVE;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(450, 8, 50);
      test_random(450, 50, 8);
      test_random(400, 0, 0);
      test_backpressure();
      drain();
      if (errors == 0 && expected_plans.size() == 0)
         $display("tb_present_viewport_planner OK");
      else
         $display("tb_present_viewport_planner NOT OK");
      $finish;
   end
endmodule
